/* design/sync_length_frame_deframer_assert.svh */
// Assertion macros shared by the frame deframer modules.
`ifndef SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_FRAME_DEFRAMER_ASSERT_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define SLFD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deframer assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define SLFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deframer assertion failed");

`endif

/* design/slfd_pkg.sv */
// Shared types and constants for the sync/length frame deframer.
package slfd_pkg;

   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CsrIndexWidth = 2;

   typedef logic [ByteWidth-1:0] byte_type;

   // Register indexes on the configuration port
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_SYNC_FIRST  = 2'd0,
      CSR_SYNC_SECOND = 2'd1,
      CSR_END_MARKER  = 2'd2
   } csr_index_type;

   localparam byte_type SyncFirstReset  = 8'hEE;
   localparam byte_type SyncSecondReset = 8'hEF;
   localparam byte_type EndMarkerReset  = 8'hFF;

   // Parser phases
   typedef enum logic [2:0] {
      PH_SYNC0 = 3'd0,
      PH_SYNC1 = 3'd1,
      PH_KIND  = 3'd2,
      PH_LEN   = 3'd3,
      PH_DATA  = 3'd4,
      PH_CHECK = 3'd5,
      PH_END   = 3'd6
   } phase_type;

   typedef struct packed {
      byte_type sync_first;
      byte_type sync_second;
      byte_type end_marker;
   } cfg_type;

   typedef struct packed {
      logic     payload_valid;
      byte_type payload_byte;
      byte_type payload_index;
      logic     payload_last;
      logic     frame_done;
      logic     frame_dropped;
      byte_type frame_kind;
      byte_type frame_length;
      byte_type check_byte;
   } result_type;

endpackage

/* design/sync_length_frame_deframer.sv */
// Top level: input register, frame parser and result register.
//
//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_rx_byte
//  rsp     | out       | rsp_valid / rsp_ready | payload, frame status, kind, length, check
//  csr     | in        | csr_write_en          | csr_index, csr_write_data
//
// One byte per cycle sustained while rsp is not stalled; each byte passes through the input
// register, then the result register, before it is presented on rsp.
// Reset clears both pipeline valids, the parser to hunting and the registers to defaults.
// A stall on rsp holds the result register; req_ready stays high while the input
// register can move on in the same cycle.
`include "sync_length_frame_deframer_assert.svh"

module sync_length_frame_deframer (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  slfd_pkg::byte_type                 req_rx_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic                               rsp_payload_valid,
   output slfd_pkg::byte_type                 rsp_payload_byte,
   output slfd_pkg::byte_type                 rsp_payload_index,
   output logic                               rsp_payload_last,
   output logic                               rsp_frame_done,
   output logic                               rsp_frame_dropped,
   output slfd_pkg::byte_type                 rsp_frame_kind,
   output slfd_pkg::byte_type                 rsp_frame_length,
   output slfd_pkg::byte_type                 rsp_check_byte,
   input  logic                               csr_write_en,
   input  logic [slfd_pkg::CsrIndexWidth-1:0] csr_index,
   input  slfd_pkg::byte_type                 csr_write_data
);
   import slfd_pkg::*;

   cfg_type    cfg;
   logic       in_valid_ff;
   byte_type   in_byte_ff;
   logic       out_valid_ff;
   result_type out_result_ff;
   result_type parse_result;
   logic       out_free;
   logic       advance;

   // Move a byte into the result register when it is empty or being taken
   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   slfd_csr u_csr (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_write_data (csr_write_data),
      .cfg            (cfg)
   );

   slfd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (advance),
      .rx_byte (in_byte_ff),
      .cfg     (cfg),
      .result  (parse_result)
   );

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_rx_byte;
      end
   end

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_result_ff <= parse_result;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_payload_valid = out_result_ff.payload_valid;
   assign rsp_payload_byte  = out_result_ff.payload_byte;
   assign rsp_payload_index = out_result_ff.payload_index;
   assign rsp_payload_last  = out_result_ff.payload_last;
   assign rsp_frame_done    = out_result_ff.frame_done;
   assign rsp_frame_dropped = out_result_ff.frame_dropped;
   assign rsp_frame_kind    = out_result_ff.frame_kind;
   assign rsp_frame_length  = out_result_ff.frame_length;
   assign rsp_check_byte    = out_result_ff.check_byte;

   `SLFD_ASSERT_SAME(a_done_drop_exclusive, clock, reset,
      rsp_valid, !(rsp_frame_done && rsp_frame_dropped))
   `SLFD_ASSERT_SAME(a_payload_not_close, clock, reset,
      rsp_valid && rsp_payload_valid, !rsp_frame_done && !rsp_frame_dropped)
   `SLFD_ASSERT_NEXT(a_stalled_input_held, clock, reset,
      in_valid_ff && !out_free, in_valid_ff && $stable(in_byte_ff))

endmodule

/* design/slfd_csr.sv */
// Configuration registers: sync bytes and end marker.
module slfd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_en,
   input  logic [slfd_pkg::CsrIndexWidth-1:0] csr_index,
   input  slfd_pkg::byte_type                 csr_write_data,
   output slfd_pkg::cfg_type                  cfg
);
   import slfd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Decode the write index; unknown indexes are ignored
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_SYNC_FIRST:  cfg_in.sync_first  = csr_write_data;
            CSR_SYNC_SECOND: cfg_in.sync_second = csr_write_data;
            CSR_END_MARKER:  cfg_in.end_marker  = csr_write_data;
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_first  <= SyncFirstReset;
         cfg_ff.sync_second <= SyncSecondReset;
         cfg_ff.end_marker  <= EndMarkerReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

/* design/slfd_parser.sv */
// Frame parser state machine: one byte per step, one result per byte.
`include "sync_length_frame_deframer_assert.svh"

module slfd_parser (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 step,
   input  slfd_pkg::byte_type   rx_byte,
   input  slfd_pkg::cfg_type    cfg,
   output slfd_pkg::result_type result
);
   import slfd_pkg::*;

   phase_type phase_ff, phase_in;
   byte_type  count_ff, count_in;
   byte_type  len_ff, len_in;
   byte_type  kind_ff, kind_in;
   byte_type  check_ff, check_in;
   logic      close_frame;
   logic [ByteWidth:0] count_next;

   assign count_next = {1'b0, count_ff} + 1'b1;

   // Next state and result for the byte at the input
   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      check_in = check_ff;
      result   = '0;
      unique case (phase_ff)
         PH_SYNC1: begin
            if (rx_byte == cfg.sync_second) begin
               phase_in = PH_KIND;
            end else begin
               result.frame_dropped = 1'b1;
            end
         end
         PH_KIND: begin
            kind_in  = rx_byte;
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            len_in   = rx_byte;
            count_in = '0;
            phase_in = (rx_byte != '0) ? PH_DATA : PH_CHECK;
         end
         PH_DATA: begin
            result.payload_valid = 1'b1;
            result.payload_byte  = rx_byte;
            result.payload_index = count_ff;
            if (count_next >= {1'b0, len_ff}) begin
               result.payload_last = 1'b1;
               phase_in = PH_CHECK;
            end
            count_in = count_next[ByteWidth-1:0];
         end
         PH_CHECK: begin
            check_in = rx_byte;
            phase_in = PH_END;
         end
         PH_END: begin
            if (rx_byte == cfg.end_marker) begin
               result.frame_done = 1'b1;
               result.check_byte = check_ff;
            end else begin
               result.frame_dropped = 1'b1;
            end
         end
         default: begin
            // Hunt for the first sync byte; the unused code hunts too
            phase_in = (rx_byte == cfg.sync_first) ? PH_SYNC1 : PH_SYNC0;
         end
      endcase

      result.frame_kind   = kind_in;
      result.frame_length = len_in;

      // Drop the frame context once the frame closes either way
      close_frame = result.frame_done | result.frame_dropped;
      if (close_frame) begin
         phase_in = PH_SYNC0;
         count_in = '0;
         len_in   = '0;
         kind_in  = '0;
         check_in = '0;
      end
   end

   // Advance state only when a byte moves through
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_SYNC0;
         count_ff <= '0;
         len_ff   <= '0;
         kind_ff  <= '0;
         check_ff <= '0;
      end else if (step) begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         len_ff   <= len_in;
         kind_ff  <= kind_in;
         check_ff <= check_in;
      end
   end

   `SLFD_ASSERT_SAME(a_data_count_in_range, clock, reset, phase_ff == PH_DATA, count_ff < len_ff)
   `SLFD_ASSERT_SAME(a_hunt_context_clear, clock, reset, phase_ff == PH_SYNC0, kind_ff == '0 && len_ff == '0 && check_ff == '0)
   `SLFD_ASSERT_NEXT(a_close_returns_to_hunt, clock, reset, step && close_frame, phase_ff == PH_SYNC0)

endmodule
